@@ src/dpdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_pkg
// Shared types and constants of the dual pad double click mode control.
// ----------------------------------------------------------------------------
package dpdc_pkg;

  localparam int unsigned NumButtons = 4;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CountW     = 4;

  localparam logic [CountW-1:0] CountMax = 4'd15;
  localparam logic [CountW-1:0] CountDc  = 4'd2;

  localparam logic [CfgW-1:0] ClickGapRst   = 16'd500;
  localparam logic [CfgW-1:0] DcValidRst    = 16'd1000;
  localparam logic [CfgW-1:0] CrossWinRst   = 16'd250;
  localparam logic [CfgW-1:0] ToggleLockRst = 16'd500;

  typedef enum logic [1:0] {
    CfgClickGap   = 2'd0,
    CfgDcValid    = 2'd1,
    CfgCrossWin   = 2'd2,
    CfgToggleLock = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] click_gap;
    logic [CfgW-1:0] dc_valid;
    logic [CfgW-1:0] cross_win;
    logic [CfgW-1:0] toggle_lock;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic             button_a;
    logic             button_b;
    logic [TimeW-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [NumButtons-1:0][TimeW-1:0]  press_stamp;
    logic [NumButtons-1:0][CountW-1:0] click_count;
    logic [NumButtons-1:0]             prev_level;
    logic                              mode_bit;
    logic                              right_prec;
    logic                              left_prec;
    logic [TimeW-1:0]                  right_tog_stamp;
    logic [TimeW-1:0]                  left_tog_stamp;
  } state_t;

  typedef struct packed {
    logic arm_mode;
    logic mode_changed;
    logic head_resync;
    logic right_precision;
    logic right_toggled;
    logic left_precision;
    logic left_toggled;
    logic motion_enabled;
  } result_t;

endpackage

@@ src/dual_pad_double_click_mode_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pad_double_click_mode_control
// Double click detection on two button pads, driving BASE/ARM mode and the
// per-side precision flags.
// ----------------------------------------------------------------------------
// usage:
//   input request: one sample of one pad (op selects right or left), both
//   button levels and a millisecond timestamp, taken when in_valid_i is high
//   and in_stall_o is low.
//   output request: one result per sample, in order, taken when out_valid_o
//   is high and out_stall_i is low.
//   path: the sample is held in the input register, updated combinationally
//   against the button records and registered in the result register,
//   which raises out_valid_o; a stalled output can keep the sample waiting
//   in the input register.
//   throughput: one sample per cycle while the output is not stalled; the
//   button records are updated in the same cycle as the sample leaves the
//   input register, so the next sample sees them at once.
//   stall: while the result register is held, one more sample waits in the
//   input register; in_stall_o rises only when both are full.
//   reset: all records, counts, flags and stamps clear, mode is BASE and the
//   thresholds return to 500, 1000, 250 and 500 ms.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once.
// ----------------------------------------------------------------------------
module dual_pad_double_click_mode_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic        button_a_i,
  input  logic        button_b_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        arm_mode_o,
  output logic        mode_changed_o,
  output logic        head_resync_o,
  output logic        right_precision_o,
  output logic        right_toggled_o,
  output logic        left_precision_o,
  output logic        left_toggled_o,
  output logic        motion_enabled_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  dpdc_pkg::cfg_t    cfg_q;
  dpdc_pkg::sample_t smp_q;
  dpdc_pkg::state_t  state_q, state_d;
  dpdc_pkg::result_t res_q, res_d;
  logic              smp_valid_q;
  logic              out_valid_q;
  logic              out_free;
  logic              advance;
  logic              in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = smp_valid_q && out_free;
  assign in_stall_o = smp_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_gap   <= dpdc_pkg::ClickGapRst;
      cfg_q.dc_valid    <= dpdc_pkg::DcValidRst;
      cfg_q.cross_win   <= dpdc_pkg::CrossWinRst;
      cfg_q.toggle_lock <= dpdc_pkg::ToggleLockRst;
    end else if (cfg_we_i) begin
      case (dpdc_pkg::cfg_idx_e'(cfg_idx_i))
        dpdc_pkg::CfgClickGap:   cfg_q.click_gap   <= cfg_data_i;
        dpdc_pkg::CfgDcValid:    cfg_q.dc_valid    <= cfg_data_i;
        dpdc_pkg::CfgCrossWin:   cfg_q.cross_win   <= cfg_data_i;
        dpdc_pkg::CfgToggleLock: cfg_q.toggle_lock <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_accept) begin
      smp_valid_q <= 1'b1;
    end else if (advance) begin
      smp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q.op       <= op_i;
      smp_q.button_a <= button_a_i;
      smp_q.button_b <= button_b_i;
      smp_q.time_ms  <= time_ms_i;
    end
  end

  dpdc_update u_update (
    .cfg_i (cfg_q),
    .smp_i (smp_q),
    .st_i  (state_q),
    .st_o  (state_d),
    .res_o (res_d)
  );

  // button records, mode and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= smp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign arm_mode_o        = res_q.arm_mode;
  assign mode_changed_o    = res_q.mode_changed;
  assign head_resync_o     = res_q.head_resync;
  assign right_precision_o = res_q.right_precision;
  assign right_toggled_o   = res_q.right_toggled;
  assign left_precision_o  = res_q.left_precision;
  assign left_toggled_o    = res_q.left_toggled;
  assign motion_enabled_o  = res_q.motion_enabled;

  // a mode flip reaches the stored mode bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.mode_changed |=> state_q.mode_bit != $past(state_q.mode_bit))
    else $error("mode flip not stored");

  // at most one of mode flip and the two toggles per sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> $onehot0({res_d.mode_changed, res_d.right_toggled, res_d.left_toggled}))
    else $error("more than one action for one sample");

  // head re-sync only on a flip into BASE
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.head_resync |-> res_d.mode_changed && !res_d.arm_mode)
    else $error("head re-sync without switch into BASE");

  // a held sample stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_q && !advance |=> smp_valid_q && $stable(smp_q))
    else $error("waiting sample lost");

  // records change only when a sample moves to the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("records changed without a sample");

endmodule

@@ src/dpdc_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpdc_update
// Next state and result for one pad sample: click runs, double click
// detection, mode flip and precision toggles.
// ----------------------------------------------------------------------------
module dpdc_update (
  input  dpdc_pkg::cfg_t    cfg_i,
  input  dpdc_pkg::sample_t smp_i,
  input  dpdc_pkg::state_t  st_i,
  output dpdc_pkg::state_t  st_o,
  output dpdc_pkg::result_t res_o
);

  logic [dpdc_pkg::NumButtons-1:0][dpdc_pkg::TimeW-1:0] age;
  logic [dpdc_pkg::NumButtons-1:0]                      lvl;
  logic [dpdc_pkg::NumButtons-1:0]                      on_pad;
  logic [dpdc_pkg::NumButtons-1:0]                      press;
  logic [dpdc_pkg::NumButtons-1:0]                      btn_dc;
  logic [dpdc_pkg::NumButtons-1:0]                      recent;
  logic [dpdc_pkg::TimeW-1:0]                           gap_w;
  logic [dpdc_pkg::TimeW-1:0]                           dcv_w;
  logic [dpdc_pkg::TimeW-1:0]                           cross_w;
  logic [dpdc_pkg::TimeW-1:0]                           lock_w;
  logic                                                 right_dc;
  logic                                                 left_dc;
  logic                                                 right_ok;
  logic                                                 left_ok;

  assign gap_w   = {16'd0, cfg_i.click_gap};
  assign dcv_w   = {16'd0, cfg_i.dc_valid};
  assign cross_w = {16'd0, cfg_i.cross_win};
  assign lock_w  = {16'd0, cfg_i.toggle_lock};

  always_comb begin
    st_o = st_i;
    for (int k = 0; k < dpdc_pkg::NumButtons; k++) begin
      on_pad[k] = (k / 2 == 1) == smp_i.op;
      lvl[k]    = (k % 2 == 1) ? smp_i.button_b : smp_i.button_a;
      press[k]  = on_pad[k] && lvl[k] && !st_i.prev_level[k];
      age[k]    = smp_i.time_ms - st_i.press_stamp[k];
      if (press[k]) begin
        if (age[k] > gap_w) begin
          st_o.click_count[k] = 4'd1;
        end else if (st_i.click_count[k] < dpdc_pkg::CountMax) begin
          st_o.click_count[k] = st_i.click_count[k] + 4'd1;
        end
        st_o.press_stamp[k] = smp_i.time_ms;
        // a fresh press is zero ms old
        age[k] = '0;
      end
      if (on_pad[k]) begin
        st_o.prev_level[k] = lvl[k];
      end
      btn_dc[k] = (st_o.click_count[k] >= dpdc_pkg::CountDc) && (age[k] < dcv_w);
      recent[k] = age[k] < cross_w;
    end

    right_dc = btn_dc[0] && btn_dc[1];
    left_dc  = btn_dc[2] && btn_dc[3];
    right_ok = !(recent[2] || recent[3]) &&
               ((smp_i.time_ms - st_i.right_tog_stamp) > lock_w);
    left_ok  = !(recent[0] || recent[1]) &&
               ((smp_i.time_ms - st_i.left_tog_stamp) > lock_w);

    res_o = '0;
    if (right_dc && left_dc) begin
      st_o.mode_bit     = !st_i.mode_bit;
      st_o.click_count  = '0;
      res_o.mode_changed = 1'b1;
      res_o.head_resync  = st_i.mode_bit;
    end else if (right_dc) begin
      if (right_ok) begin
        st_o.right_prec      = !st_i.right_prec;
        st_o.right_tog_stamp = smp_i.time_ms;
        st_o.click_count[0]  = '0;
        st_o.click_count[1]  = '0;
        res_o.right_toggled  = 1'b1;
      end
    end else if (left_dc) begin
      if (left_ok) begin
        st_o.left_prec      = !st_i.left_prec;
        st_o.left_tog_stamp = smp_i.time_ms;
        st_o.click_count[2] = '0;
        st_o.click_count[3] = '0;
        res_o.left_toggled  = 1'b1;
      end
    end

    res_o.arm_mode        = st_o.mode_bit;
    res_o.motion_enabled  = !st_o.mode_bit;
    res_o.right_precision = st_o.right_prec;
    res_o.left_precision  = st_o.left_prec;
  end

endmodule

@@ sim/dual_pad_double_click_mode_control_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pad_double_click_mode_control_tb
// Sends button samples of both pads through the valid/stall ports with random
// gaps and output stalls. Mode and precision flags are predicted per sample
// and compared in order with each result. The click thresholds are rewritten
// between phases, the extremes among them.
// ----------------------------------------------------------------------------
module dual_pad_double_click_mode_control_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DirRows    = 25;
  localparam int unsigned PhaseItems = 70;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned HoldCycles = 150;

  typedef struct packed {
    dpdc_pkg::sample_t smp;
    logic              known;
    dpdc_pkg::result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic        button_a_i = 1'b0;
  logic        button_b_i = 1'b0;
  logic [31:0] time_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        arm_mode_o;
  logic        mode_changed_o;
  logic        head_resync_o;
  logic        right_precision_o;
  logic        right_toggled_o;
  logic        left_precision_o;
  logic        left_toggled_o;
  logic        motion_enabled_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  dpdc_pkg::state_t  pad_st = '0;
  dpdc_pkg::cfg_t    thr_cfg = '{dpdc_pkg::ClickGapRst, dpdc_pkg::DcValidRst,
                                 dpdc_pkg::CrossWinRst, dpdc_pkg::ToggleLockRst};
  dpdc_pkg::result_t flag_update_q [$];
  logic [31:0]       now_ms = '0;
  int unsigned       items_sent = 0;
  int unsigned       bad_results = 0;
  int unsigned       checked_cnt = 0;
  int unsigned       cycle_cnt = 0;
  bit                idle_on = 1'b1;
  bit                long_hold_req = 1'b0;

  // reset row and a press at time zero are known outright, the rest is predicted
  dir_row_t dir_tab [0:DirRows-1] = '{
    '{'{1'b0, 1'b0, 1'b0, 32'd0},          1'b1, 8'h01},
    '{'{1'b1, 1'b1, 1'b1, 32'd0},          1'b1, 8'h01},
    '{'{1'b1, 1'b0, 1'b0, 32'd10},         1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd20},         1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd600},        1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd700},        1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd800},        1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd900},        1'b0, 8'h00},
    '{'{1'b0, 1'b1, 1'b1, 32'd1000},       1'b0, 8'h00},
    '{'{1'b0, 1'b0, 1'b0, 32'd1010},       1'b0, 8'h00},
    '{'{1'b0, 1'b1, 1'b1, 32'd1020},       1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd1030},       1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd1040},       1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd1050},       1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd1060},       1'b0, 8'h00},
    '{'{1'b0, 1'b0, 1'b0, 32'd1070},       1'b0, 8'h00},
    '{'{1'b0, 1'b1, 1'b1, 32'd1080},       1'b0, 8'h00},
    '{'{1'b0, 1'b0, 1'b0, 32'd1090},       1'b0, 8'h00},
    '{'{1'b0, 1'b1, 1'b1, 32'd1100},       1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd1110},       1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd1120},       1'b0, 8'h00},
    '{'{1'b1, 1'b0, 1'b0, 32'd1130},       1'b0, 8'h00},
    '{'{1'b1, 1'b1, 1'b1, 32'd1140},       1'b0, 8'h00},
    '{'{1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF},  1'b0, 8'h00},
    '{'{1'b0, 1'b1, 1'b1, 32'd5},          1'b0, 8'h00}
  };

  dual_pad_double_click_mode_control uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] age_ms(input logic [31:0] now, input logic [31:0] stamp);
    return now - stamp;
  endfunction

  function automatic logic click_live(input int unsigned k, input logic [31:0] now);
    return (pad_st.click_count[k] >= dpdc_pkg::CountDc) &&
           (age_ms(now, pad_st.press_stamp[k]) < {16'd0, thr_cfg.dc_valid});
  endfunction

  function automatic logic pad_busy(input int unsigned pad, input logic [31:0] now);
    return (age_ms(now, pad_st.press_stamp[2*pad]) < {16'd0, thr_cfg.cross_win}) ||
           (age_ms(now, pad_st.press_stamp[2*pad+1]) < {16'd0, thr_cfg.cross_win});
  endfunction

  function automatic dpdc_pkg::result_t apply_pad_sample(input dpdc_pkg::sample_t s);
    int unsigned       i;
    int unsigned       k;
    logic [1:0]        lvl;
    logic              r_dc;
    logic              l_dc;
    dpdc_pkg::result_t r;
    lvl = {s.button_b, s.button_a};
    for (i = 0; i < 2; i++) begin
      k = 2 * s.op + i;
      if (lvl[i] && !pad_st.prev_level[k]) begin
        if (age_ms(s.time_ms, pad_st.press_stamp[k]) > {16'd0, thr_cfg.click_gap})
          pad_st.click_count[k] = 4'd1;
        else if (pad_st.click_count[k] < dpdc_pkg::CountMax)
          pad_st.click_count[k] = pad_st.click_count[k] + 4'd1;
        pad_st.press_stamp[k] = s.time_ms;
      end
      pad_st.prev_level[k] = lvl[i];
    end
    r_dc = click_live(0, s.time_ms) && click_live(1, s.time_ms);
    l_dc = click_live(2, s.time_ms) && click_live(3, s.time_ms);
    r = '0;
    if (r_dc && l_dc) begin
      pad_st.mode_bit = !pad_st.mode_bit;
      r.mode_changed = 1'b1;
      r.head_resync = !pad_st.mode_bit;
      pad_st.click_count = '0;
    end else if (r_dc) begin
      // lone pad: other pad must be quiet and the lockout passed
      if (!pad_busy(1, s.time_ms) &&
          age_ms(s.time_ms, pad_st.right_tog_stamp) > {16'd0, thr_cfg.toggle_lock}) begin
        pad_st.right_prec = !pad_st.right_prec;
        pad_st.right_tog_stamp = s.time_ms;
        pad_st.click_count[0] = '0;
        pad_st.click_count[1] = '0;
        r.right_toggled = 1'b1;
      end
    end else if (l_dc) begin
      if (!pad_busy(0, s.time_ms) &&
          age_ms(s.time_ms, pad_st.left_tog_stamp) > {16'd0, thr_cfg.toggle_lock}) begin
        pad_st.left_prec = !pad_st.left_prec;
        pad_st.left_tog_stamp = s.time_ms;
        pad_st.click_count[2] = '0;
        pad_st.click_count[3] = '0;
        r.left_toggled = 1'b1;
      end
    end
    r.arm_mode = pad_st.mode_bit;
    r.right_precision = pad_st.right_prec;
    r.left_precision = pad_st.left_prec;
    r.motion_enabled = !pad_st.mode_bit;
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // called and returns at a falling edge; valid is left high for the next request
  task automatic send_sample(input dpdc_pkg::sample_t s, input logic known,
                             input dpdc_pkg::result_t known_res);
    int unsigned       gap;
    dpdc_pkg::result_t pred;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= s.op;
    button_a_i <= s.button_a;
    button_b_i <= s.button_b;
    time_ms_i <= s.time_ms;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_pad_sample(s);
    flag_update_q.insert(flag_update_q.size(), known ? known_res : pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  // pace 0 normal, 1 fast clicking, 2 anything incl. wrapping jumps
  task automatic tap(input logic pad, input logic a, input logic b, input int unsigned pace);
    int unsigned       span;
    int unsigned       roll;
    dpdc_pkg::sample_t s;
    span = (thr_cfg.click_gap > thr_cfg.dc_valid) ? {16'd0, thr_cfg.click_gap} :
                                                    {16'd0, thr_cfg.dc_valid};
    roll = $urandom_range(0, 99);
    if (pace == 1 || roll < 50) now_ms += $urandom_range(0, 40);
    else if (pace == 2 && roll < 70) now_ms += $urandom();
    else if (roll < 85) now_ms += $urandom_range(0, 2 * span + 20);
    else now_ms += $urandom_range(0, 1000);
    s = '{pad, a, b, now_ms};
    send_sample(s, 1'b0, '0);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned reps;
    logic        p;
    logic        a;
    logic        b;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      p = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 6) == 0) begin
        a = 1'($urandom_range(0, 1));
        b = !a;
      end else begin
        a = 1'b1;
        b = 1'b1;
      end
      if (kind < 45) begin
        reps = $urandom_range(2, 3);
        repeat (reps) begin
          tap(p, a, b, 0);
          tap(p, 1'b0, 1'b0, 0);
        end
      end else if (kind < 75) begin
        // interleaved clicks on both pads, aims at a mode flip
        repeat (2) begin
          tap(p, a, b, 0);
          tap(p, 1'b0, 1'b0, 0);
          tap(!p, 1'b1, 1'b1, 0);
          tap(!p, 1'b0, 1'b0, 0);
        end
      end else if (kind < 85) begin
        reps = $urandom_range(4, 18);
        repeat (reps) begin
          tap(p, a, b, 1);
          tap(p, 1'b0, 1'b0, 1);
        end
      end else begin
        reps = $urandom_range(1, 6);
        repeat (reps) tap(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (flag_update_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_cfg(input dpdc_pkg::cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= dpdc_pkg::CfgClickGap;
    cfg_data_i <= c.click_gap;
    @(negedge clk_i);
    cfg_idx_i <= dpdc_pkg::CfgDcValid;
    cfg_data_i <= c.dc_valid;
    @(negedge clk_i);
    cfg_idx_i <= dpdc_pkg::CfgCrossWin;
    cfg_data_i <= c.cross_win;
    @(negedge clk_i);
    cfg_idx_i <= dpdc_pkg::CfgToggleLock;
    cfg_data_i <= c.toggle_lock;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_cfg = c;
  endtask

  initial begin : stimulus
    dpdc_pkg::cfg_t phase_tab [NumPhases];
    int unsigned    i;
    phase_tab[0] = '{dpdc_pkg::ClickGapRst, dpdc_pkg::DcValidRst,
                     dpdc_pkg::CrossWinRst, dpdc_pkg::ToggleLockRst};
    phase_tab[1] = '0;
    phase_tab[2] = '1;
    phase_tab[3] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
    phase_tab[4] = '{16'd300, 16'd700, 16'd100, 16'd200};
    phase_tab[5] = '{16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200)),
                     16'($urandom_range(0, 1200)), 16'($urandom_range(0, 1200))};
    phase_tab[6] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < DirRows; i++) begin
      now_ms = dir_tab[i].smp.time_ms;
      send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].res);
    end
    for (i = 0; i < NumPhases; i++) begin
      drain_results();
      set_cfg(phase_tab[i]);
      idle_on = (i != 2);
      random_traffic(PhaseItems);
      if (i == 3) begin
        // receiver holds off while requests keep coming, so the input backs up
        drain_results();
        long_hold_req = 1'b1;
        idle_on = 1'b0;
        repeat (3) begin
          tap(1'b0, 1'b1, 1'b1, 1);
          tap(1'b0, 1'b0, 1'b0, 1);
          tap(1'b1, 1'b1, 1'b1, 1);
          tap(1'b1, 1'b0, 1'b0, 1);
        end
        drain_results();
        idle_on = 1'b1;
      end
    end
    drain_results();
    repeat (10) @(posedge clk_i);
    if (bad_results == 0 && flag_update_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : out_stall_gen
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    dpdc_pkg::result_t got;
    dpdc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {arm_mode_o, mode_changed_o, head_resync_o, right_precision_o,
             right_toggled_o, left_precision_o, left_toggled_o, motion_enabled_o};
      if (flag_update_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d with no request pending: got %b", checked_cnt, got);
      end else begin
        want = flag_update_q.pop_front();
        if (got.arm_mode !== want.arm_mode || got.mode_changed !== want.mode_changed ||
            got.head_resync !== want.head_resync ||
            got.right_precision !== want.right_precision ||
            got.right_toggled !== want.right_toggled ||
            got.left_precision !== want.left_precision ||
            got.left_toggled !== want.left_toggled ||
            got.motion_enabled !== want.motion_enabled) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d mismatch (arm,chg,resync,rprec,rtog,lprec,ltog,motion): %s",
                     checked_cnt, $sformatf("expected %b got %b", want, got));
        end
      end
      checked_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
